>>> hw/rtl/skvt_pkg.sv
// sorted key/value table: shared types, codes and sizes
// used by sorted_key_value_table_core; depends on nothing
`default_nettype none
package skvt_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 64;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 7;
  localparam int ENTRY_W  = KEY_W + VALUE_W;

  // s_tdata: cmd, key, data_word; m_tdata: status, read_word, fill_count
  localparam int S_FIELDS_W = CMD_W + KEY_W + VALUE_W;
  localparam int M_FIELDS_W = STATUS_W + VALUE_W + FILL_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_INDEX_BASE = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_COMPARE,
    S_LOOK_CHK,
    S_SHIFT,
    S_WRITE,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

>>> hw/rtl/skvt_ram.sv
// generic single-write, single-read ram with registered read data
// stand-alone; no package dependency
`default_nettype none
module skvt_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/sorted_key_value_table_core.sv
// sorted key/value table over skvt_ram and skvt_pkg: binary search, insertion by shifting up
// each search step reads the entry at mid (S_SEARCH) and compares keys (S_COMPARE); then a
//   lookup checks the key found, an insert shifts entries up and writes; a refused word goes to S_DONE
// throughput: one word at a time; the next is taken in the cycle after the result is issued,
//   and a result that waits on m_tready holds the block
// reset: entry count, index_base and handshakes clear; ram contents are not cleared
`default_nettype none
module sorted_key_value_table_core #(
  parameter int DEPTH = skvt_pkg::DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // apb configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [skvt_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [skvt_pkg::PDATA_W-1:0]  pwdata,
  output logic      [skvt_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  // input words
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [skvt_pkg::S_TDATA_W-1:0] s_tdata, // cmd[1:0], key[33:2], data_word[97:34]
  // result words
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [skvt_pkg::M_TDATA_W-1:0] m_tdata  // status[1:0], read_word[65:2], fill_count[72:66]
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = skvt_pkg::KEY_W;
  localparam int VW = skvt_pkg::VALUE_W;
  localparam int EW = skvt_pkg::ENTRY_W;
  localparam int FW = skvt_pkg::FILL_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  skvt_pkg::state_t state, state_next;

  logic [skvt_pkg::CMD_W-1:0]    cmd_r;
  logic [KW-1:0]                 key_r;
  logic [VW-1:0]                 data_r;
  logic [CW-1:0]                 lo, hi, mid_r, j, count;
  logic [KW-1:0]                 base;
  logic [skvt_pkg::STATUS_W-1:0] status_r;
  logic [VW-1:0]                 word_r;

  logic [skvt_pkg::CMD_W-1:0] in_cmd;
  logic [KW-1:0]              in_key;
  logic [VW-1:0]              in_data;
  logic                       accept, is_lookup, in_insert, out_free;
  logic [CW-1:0]              mid, raddr_full, waddr_full;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [EW-1:0]              ram_wdata, ram_rdata;
  logic [KW-1:0]              rd_key;
  logic [VW-1:0]              rd_value;
  logic [CW+FW-1:0]           count_wide;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == skvt_pkg::REG_INDEX_BASE) ? base : '0;

  assign in_cmd  = s_tdata[1:0];
  assign in_key  = s_tdata[33:2];
  assign in_data = s_tdata[97:34];
  assign accept  = s_tvalid && s_tready;
  assign in_insert = (in_cmd == skvt_pkg::CMD_LOAD) || (in_cmd == skvt_pkg::CMD_INSERT);
  assign is_lookup = (cmd_r == skvt_pkg::CMD_LOOKUP);
  assign out_free  = !m_tvalid || m_tready;

  assign mid      = lo + ((hi - lo) >> 1);
  assign rd_key   = ram_rdata[EW-1:VW];
  assign rd_value = ram_rdata[VW-1:0];
  assign count_wide = {{FW{1'b0}}, count};

  skvt_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH),
    .ADDR_W(AW)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      skvt_pkg::S_IDLE: begin
        if (accept) begin
          if (in_cmd == skvt_pkg::CMD_LOOKUP) begin
            state_next = skvt_pkg::S_SEARCH;
          end else if (in_insert && count != FULL_COUNT) begin
            state_next = skvt_pkg::S_SEARCH;
          end else begin
            state_next = skvt_pkg::S_DONE;
          end
        end
      end
      skvt_pkg::S_SEARCH: begin
        if (lo < hi) begin
          state_next = skvt_pkg::S_COMPARE;
        end else if (is_lookup) begin
          state_next = (lo < count) ? skvt_pkg::S_LOOK_CHK : skvt_pkg::S_DONE;
        end else begin
          state_next = (lo == count) ? skvt_pkg::S_WRITE : skvt_pkg::S_SHIFT;
        end
      end
      skvt_pkg::S_COMPARE:  state_next = skvt_pkg::S_SEARCH;
      skvt_pkg::S_LOOK_CHK: state_next = skvt_pkg::S_DONE;
      skvt_pkg::S_SHIFT: begin
        if (j == lo) begin
          state_next = skvt_pkg::S_WRITE;
        end
      end
      skvt_pkg::S_WRITE: state_next = skvt_pkg::S_DONE;
      skvt_pkg::S_DONE: begin
        if (out_free) begin
          state_next = skvt_pkg::S_IDLE;
        end
      end
      default: state_next = skvt_pkg::S_IDLE;
    endcase
  end

  // ram control and handshake outputs
  always_comb begin
    s_tready   = 1'b0;
    ram_we     = 1'b0;
    raddr_full = mid;
    waddr_full = lo;
    ram_wdata  = {key_r, data_r};
    case (state)
      skvt_pkg::S_IDLE: s_tready = 1'b1;
      skvt_pkg::S_SEARCH: begin
        if (lo < hi) begin
          raddr_full = mid;
        end else if (is_lookup) begin
          raddr_full = lo;
        end else begin
          raddr_full = count - 1'b1;
        end
      end
      skvt_pkg::S_SHIFT: begin
        ram_we     = 1'b1;
        waddr_full = j + 1'b1;
        ram_wdata  = ram_rdata;
        raddr_full = j - 1'b1;
      end
      skvt_pkg::S_WRITE: begin
        ram_we     = 1'b1;
        waddr_full = lo;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign ram_raddr = raddr_full[AW-1:0];
  assign ram_waddr = waddr_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= skvt_pkg::S_IDLE;
      count    <= '0;
      base     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (psel && penable && pwrite && pready && paddr[2] == skvt_pkg::REG_INDEX_BASE) begin
        base <= pwdata;
      end
      if (state == skvt_pkg::S_WRITE) begin
        count <= count + 1'b1;
      end
      if (state == skvt_pkg::S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      skvt_pkg::S_IDLE: begin
        cmd_r    <= in_cmd;
        key_r    <= (in_cmd == skvt_pkg::CMD_LOAD) ? in_key - base : in_key;
        data_r   <= in_data;
        lo       <= '0;
        hi       <= count;
        word_r   <= '0;
        status_r <= (in_insert && count == FULL_COUNT) ? skvt_pkg::ST_FULL : skvt_pkg::ST_OK;
      end
      skvt_pkg::S_SEARCH: begin
        mid_r <= mid;
        j     <= count - 1'b1;
        if (!(lo < hi) && is_lookup && !(lo < count)) begin
          status_r <= skvt_pkg::ST_MISSING;
        end
      end
      skvt_pkg::S_COMPARE: begin
        if ($signed(rd_key) < $signed(key_r)) begin
          lo <= mid_r + 1'b1;
        end else begin
          hi <= mid_r;
        end
      end
      skvt_pkg::S_LOOK_CHK: begin
        if (rd_key == key_r) begin
          word_r <= rd_value;
        end else begin
          status_r <= skvt_pkg::ST_MISSING;
        end
      end
      skvt_pkg::S_SHIFT: begin
        j <= j - 1'b1;
      end
      skvt_pkg::S_DONE: begin
        if (out_free) begin
          m_tdata <= {{(skvt_pkg::M_TDATA_W - skvt_pkg::M_FIELDS_W){1'b0}},
                      count_wide[FW-1:0], word_r, status_r};
        end
      end
      default: begin
        j <= j;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> dv/sorted_key_value_table_core_tb.sv
`timescale 1ns / 100ps
// testbench for sorted_key_value_table_core: drives load, insert, lookup and unused-command words with random
// gaps and stalls, predicts each answer from its own sorted copy of the table
// depends on skvt_pkg and the core rtl
module sorted_key_value_table_core_tb;

  localparam int TABLE_DEPTH = skvt_pkg::DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int PAW = skvt_pkg::PADDR_W;
  localparam int FW = skvt_pkg::FILL_W;
  localparam logic [skvt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [PAW-1:0] ADDR_INDEX_BASE = PAW'(4 * int'(skvt_pkg::REG_INDEX_BASE));
  localparam logic [skvt_pkg::KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [skvt_pkg::KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;

  typedef struct {
    skvt_pkg::status_t               status;
    logic [skvt_pkg::VALUE_W-1:0]    word;
    logic [FW-1:0]                   fill;
  } answer_t;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [PAW-1:0]                 paddr = '0;
  logic [skvt_pkg::PDATA_W-1:0]   pwdata = '0;
  logic [skvt_pkg::PDATA_W-1:0]   prdata;
  logic                           pready;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [skvt_pkg::S_TDATA_W-1:0] s_tdata = '0;  // cmd, key, data_word
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [skvt_pkg::M_TDATA_W-1:0] m_tdata;       // status, read_word, fill_count

  answer_t                             pending_answers[$];
  logic signed [skvt_pkg::KEY_W-1:0]   held_keys[$];
  logic [skvt_pkg::VALUE_W-1:0]        held_values[$];
  logic [skvt_pkg::KEY_W-1:0]          load_offset = '0;
  int                                  mismatches = 0;
  int                                  send_idle_pct = 0;
  int                                  recv_idle_pct = 0;
  int                                  hold_left = 0;
  int                                  cycle_count = 0;

  sorted_key_value_table_core #(.DEPTH(TABLE_DEPTH)) u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("[sorted_key_value_table_core] ERROR");
        $finish;
      end
    end
  end

  function automatic int first_not_below(logic signed [skvt_pkg::KEY_W-1:0] k);
    int pos;
    pos = 0;
    while (pos < held_keys.size() && held_keys[pos] < k) pos++;
    return pos;
  endfunction

  function automatic answer_t table_answer(logic [skvt_pkg::CMD_W-1:0] cmd,
                                           logic [skvt_pkg::KEY_W-1:0] k,
                                           logic [skvt_pkg::VALUE_W-1:0] v);
    answer_t                           a;
    int                                pos;
    logic signed [skvt_pkg::KEY_W-1:0] stored;
    a.status = skvt_pkg::ST_OK;
    a.word = '0;
    stored = (cmd == skvt_pkg::CMD_LOAD) ? k - load_offset : k;
    if (cmd == skvt_pkg::CMD_LOAD || cmd == skvt_pkg::CMD_INSERT) begin
      if (held_keys.size() >= TABLE_DEPTH) begin
        a.status = skvt_pkg::ST_FULL;
      end else begin
        pos = first_not_below(stored);
        held_keys.insert(pos, stored);
        held_values.insert(pos, v);
      end
    end else if (cmd == skvt_pkg::CMD_LOOKUP) begin
      pos = first_not_below(k);
      if (pos < held_keys.size() && held_keys[pos] == $signed(k)) a.word = held_values[pos];
      else a.status = skvt_pkg::ST_MISSING;
    end
    a.fill = FW'(held_keys.size());
    return a;
  endfunction

  // half the keys are ones already held, so lookups hit and inserts make duplicates
  function automatic logic [skvt_pkg::KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50 && held_keys.size() > 0) return held_keys[$urandom_range(0, held_keys.size()-1)];
    if (sel < 60 && held_keys.size() > 0)
      return held_keys[$urandom_range(0, held_keys.size()-1)] + 1;
    if (sel < 80) return $urandom_range(0, 16) - 32'd8;
    return $urandom();
  endfunction

  task automatic check_answer();
    answer_t a;
    logic [skvt_pkg::STATUS_W-1:0] got_status;
    logic [skvt_pkg::VALUE_W-1:0]  got_word;
    logic [FW-1:0]                 got_fill;
    got_status = m_tdata[skvt_pkg::STATUS_W-1:0];
    got_word = m_tdata[skvt_pkg::STATUS_W +: skvt_pkg::VALUE_W];
    got_fill = m_tdata[skvt_pkg::STATUS_W+skvt_pkg::VALUE_W +: FW];
    if (pending_answers.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected word: expected none, got status %0d word %h fill %0d",
               $time, got_status, got_word, got_fill);
    end else begin
      a = pending_answers.pop_front();
      if (got_status !== a.status || got_word !== a.word || got_fill !== a.fill) begin
        mismatches++;
        $display("%0t: expected status %0d word %h fill %0d, got status %0d word %h fill %0d",
                 $time, a.status, a.word, a.fill, got_status, got_word, got_fill);
      end
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) check_answer();
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_word(input logic [skvt_pkg::CMD_W-1:0] cmd,
                           input logic [skvt_pkg::KEY_W-1:0] k,
                           input logic [skvt_pkg::VALUE_W-1:0] v);
    answer_t expected;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    expected = table_answer(cmd, k, v);
    pending_answers.insert(pending_answers.size(), expected);
    s_tvalid <= 1'b1;
    s_tdata <= {{(skvt_pkg::S_TDATA_W-skvt_pkg::S_FIELDS_W){1'b0}}, v, k, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_all_answered();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic set_index_base(input logic [skvt_pkg::KEY_W-1:0] base);
    wait_all_answered();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_INDEX_BASE;
    pwdata <= base;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    load_offset = base;
  endtask

  task automatic test_empty_table();
    send_word(skvt_pkg::CMD_LOOKUP, 32'd0, '0);
    send_word(skvt_pkg::CMD_LOOKUP, KEY_MIN, '1);
    send_word(CMD_UNUSED, 32'd7, 64'h1234);
  endtask

  task automatic test_extreme_keys();
    send_word(skvt_pkg::CMD_INSERT, KEY_MIN, '1);
    send_word(skvt_pkg::CMD_INSERT, KEY_MAX, '0);
    send_word(skvt_pkg::CMD_INSERT, 32'd5, 64'h1111_1111_1111_1111);
    send_word(skvt_pkg::CMD_INSERT, 32'd5, 64'h2222_2222_2222_2222);
    send_word(skvt_pkg::CMD_INSERT, 32'hffff_ffff, 64'h8000_0000_0000_0001);
    send_word(skvt_pkg::CMD_LOOKUP, 32'd5, '0);
    send_word(skvt_pkg::CMD_LOOKUP, KEY_MIN, '0);
    send_word(skvt_pkg::CMD_LOOKUP, KEY_MAX, '0);
    send_word(skvt_pkg::CMD_LOOKUP, 32'd4, '0);
    send_word(skvt_pkg::CMD_LOOKUP, 32'd6, '0);
    send_word(skvt_pkg::CMD_LOOKUP, 32'hffff_ffff, '0);
    send_word(CMD_UNUSED, '1, '1);
  endtask

  // load keys wrap when the offset is subtracted
  task automatic test_load_offset();
    set_index_base(KEY_MAX);
    send_word(skvt_pkg::CMD_LOAD, KEY_MIN, 64'hdead_beef_0000_0001);
    send_word(skvt_pkg::CMD_LOOKUP, 32'd1, '0);
    set_index_base(KEY_MIN);
    send_word(skvt_pkg::CMD_LOAD, 32'd0, 64'hcafe_0000_0000_0002);
    send_word(skvt_pkg::CMD_LOOKUP, KEY_MIN, '0);
    send_word(skvt_pkg::CMD_LOAD, KEY_MAX, 64'h0123_4567_89ab_cdef);
    send_word(skvt_pkg::CMD_LOOKUP, 32'hffff_ffff, '0);
  endtask

  task automatic test_random_items(input int sender_idle, input int receiver_idle, input int n);
    int                           sel;
    logic [skvt_pkg::VALUE_W-1:0] data;
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      data = {$urandom(), $urandom()};
      if (sel < 6) send_word(skvt_pkg::CMD_LOAD, pick_key() + load_offset, data);
      else if (sel < 12) send_word(skvt_pkg::CMD_INSERT, pick_key(), data);
      else if (sel < 14) send_word(CMD_UNUSED, $urandom(), data);
      else send_word(skvt_pkg::CMD_LOOKUP, pick_key(), data);
    end
  endtask

  // receiver stalls long while words keep coming, so the input side backs up
  task automatic test_backpressure();
    send_idle_pct = 0;
    hold_left = HOLD_CYCLES;
    repeat (24) send_word(skvt_pkg::CMD_LOOKUP, pick_key(), {$urandom(), $urandom()});
  endtask

  task automatic test_table_full();
    send_idle_pct = 10;
    recv_idle_pct = 10;
    while (held_keys.size() < TABLE_DEPTH)
      send_word(skvt_pkg::CMD_INSERT, $urandom(), {$urandom(), $urandom()});
    send_word(skvt_pkg::CMD_INSERT, pick_key(), '1);
    send_word(skvt_pkg::CMD_LOAD, KEY_MIN, '1);
    send_word(skvt_pkg::CMD_INSERT, KEY_MAX, '0);
    send_word(skvt_pkg::CMD_LOOKUP, pick_key(), '0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_extreme_keys();
    test_load_offset();
    set_index_base($urandom());
    test_random_items(18, 71, 530);
    set_index_base(KEY_MIN);
    test_backpressure();
    test_table_full();
    set_index_base(KEY_MAX);
    test_random_items(71, 18, 530);
    set_index_base('0);
    test_random_items(0, 0, 530);
    wait_all_answered();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("[sorted_key_value_table_core] OK");
    end else begin
      $display("[sorted_key_value_table_core] ERROR");
    end
    $finish;
  end

endmodule
